/* design/qcsc_pkg.sv */
`timescale 1ns / 1ps
// qcsc_pkg: shared types and constants of the catalog string counter
// no dependencies; used by the parser, the result queue and the top level

package qcsc_pkg;

    localparam int MAGIC_LEN   = 16;
    localparam int FIFO_DEPTH  = 4;
    localparam int HDR_LAST    = 4;

    localparam logic [7:0] CATALOG_MAGIC [MAGIC_LEN] = '{
        8'h3c, 8'hb8, 8'h64, 8'h18, 8'hca, 8'hef, 8'h9c, 8'h95,
        8'hcd, 8'h21, 8'h1c, 8'hbf, 8'h60, 8'ha1, 8'hbd, 8'hdd
    };

    localparam logic [7:0] SECTION_MESSAGES = 8'h69;

    localparam logic [7:0] TAG_PADDING     = 8'h01;
    localparam logic [7:0] TAG_TRANSLATION = 8'h03;
    localparam logic [7:0] TAG_FIXED4      = 8'h05;
    localparam logic [7:0] TAG_DATA6       = 8'h06;
    localparam logic [7:0] TAG_DATA7       = 8'h07;
    localparam logic [7:0] TAG_DATA8       = 8'h08;

    localparam logic [31:0] NO_BODY = 32'hffff_ffff;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_BAD_MAGIC = 2'd1;
    localparam logic [1:0] STATUS_TRUNCATED = 2'd2;

    localparam logic KIND_COUNT  = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    typedef enum logic [3:0] {
        PH_MAGIC  = 4'b0001,
        PH_HEADER = 4'b0010,
        PH_BODY   = 4'b0100,
        PH_FAILED = 4'b1000
    } phase_t;

    typedef enum logic [3:0] {
        TG_EXPECT  = 4'b0001,
        TG_LEN     = 4'b0010,
        TG_SKIP    = 4'b0100,
        TG_STOPPED = 4'b1000
    } tag_phase_t;

    // registered input item
    typedef struct packed {
        logic       valid;
        logic [7:0] data_byte;
        logic       last_byte;
    } item_t;

    // results caused by one byte: a section count, a file status, or both
    typedef struct packed {
        logic        has_count;
        logic [31:0] count;
        logic        has_status;
        logic [1:0]  status;
    } entry_t;

endpackage

/* design/qcsc_if.sv */
`timescale 1ns / 1ps
// byte_if and result_if: valid/ready channels of the catalog string counter
// no dependencies

interface byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface result_if;
    logic        valid;
    logic        ready;
    logic        result_kind;
    logic [31:0] string_count;
    logic [1:0]  status;
    logic        last_result;

    modport source (output valid, output result_kind, output string_count,
                    output status, output last_result, input ready);
    modport sink (input valid, input result_kind, input string_count,
                  input status, input last_result, output ready);
endinterface

/* design/qm_catalog_string_counter.sv */
`timescale 1ns / 1ps
// qm_catalog_string_counter: top level, input register, parser and result queue
// depends on qcsc_pkg, byte_if, result_if, qcsc_parser and qcsc_out_queue

// Takes a compiled translation catalog one byte per transfer and reports,
// for each messages section, the number of translation tags it holds, then
// a file status on the final byte. A byte can be taken in every cycle; a
// byte lands in an input register and is parsed in the following cycle,
// and its results are registered in the queue before they are offered. Results wait in
// a four-entry queue, and bytes keep flowing while results are pending as
// long as the queue has room for one more entry. The final byte of a file
// may cause two results (a section count and the status), which leave on
// two consecutive transfers; every other byte causes at most one.
module qm_catalog_string_counter (
    input  logic     clk,
    input  logic     rst_n,
    byte_if.sink     bytes,
    result_if.source results
);
    import qcsc_pkg::*;

    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

    item_t              item_reg;
    logic               push;
    entry_t             entry;
    logic [CNT_W - 1:0] q_count;
    logic [CNT_W:0]     fill;

    // room for what the registered byte pushes now plus one more entry
    assign fill        = {1'b0, q_count} + (CNT_W + 1)'(push);
    assign bytes.ready = fill < (CNT_W + 1)'(FIFO_DEPTH);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_reg.valid     <= 1'b0;
            item_reg.data_byte <= '0;
            item_reg.last_byte <= 1'b0;
        end
        else
        begin
            item_reg.valid <= bytes.valid && bytes.ready;
            if (bytes.valid && bytes.ready)
            begin
                item_reg.data_byte <= bytes.data_byte;
                item_reg.last_byte <= bytes.last_byte;
            end
        end
    end

    qcsc_parser u_parser (
        .clk   (clk),
        .rst_n (rst_n),
        .item  (item_reg),
        .push  (push),
        .entry (entry)
    );

    qcsc_out_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .entry   (entry),
        .count   (q_count),
        .results (results)
    );

endmodule

/* design/qcsc_parser.sv */
`timescale 1ns / 1ps
// qcsc_parser: magic check, section walk and tag walk, one byte per cycle
// depends on qcsc_pkg

module qcsc_parser (
    input  logic           clk,
    input  logic           rst_n,
    input  qcsc_pkg::item_t  item,
    output logic           push,
    output qcsc_pkg::entry_t entry
);
    import qcsc_pkg::*;

    phase_t      phase_reg, phase_next;
    logic [3:0]  magic_pos_reg, magic_pos_next;
    logic [2:0]  hdr_pos_reg, hdr_pos_next;
    logic        in_msg_reg, in_msg_next;
    logic [31:0] section_left_reg, section_left_next;
    logic [31:0] acc_reg, acc_next;
    tag_phase_t  tag_phase_reg, tag_phase_next;
    logic [1:0]  len_pos_reg, len_pos_next;
    logic [31:0] skip_left_reg, skip_left_next;
    logic [31:0] count_reg, count_next;

    logic [31:0] acc_shift;
    logic        closed;
    logic [31:0] closed_count;
    logic [1:0]  file_status;

    assign acc_shift = {acc_reg[23:0], item.data_byte};

    always_comb
    begin
        phase_next        = phase_reg;
        magic_pos_next    = magic_pos_reg;
        hdr_pos_next      = hdr_pos_reg;
        in_msg_next       = in_msg_reg;
        section_left_next = section_left_reg;
        acc_next          = acc_reg;
        tag_phase_next    = tag_phase_reg;
        len_pos_next      = len_pos_reg;
        skip_left_next    = skip_left_reg;
        count_next        = count_reg;
        closed            = 1'b0;
        closed_count      = '0;
        file_status       = STATUS_OK;

        if (item.valid)
        begin
            unique case (phase_reg)
                PH_MAGIC:
                begin
                    if (item.data_byte == CATALOG_MAGIC[magic_pos_reg])
                    begin
                        if (magic_pos_reg == 4'(MAGIC_LEN - 1))
                        begin
                            phase_next   = PH_HEADER;
                            hdr_pos_next = '0;
                        end
                        else
                        begin
                            magic_pos_next = magic_pos_reg + 4'd1;
                        end
                    end
                    else
                    begin
                        phase_next = PH_FAILED;
                    end
                end
                PH_HEADER:
                begin
                    if (hdr_pos_reg == '0)
                    begin
                        in_msg_next  = (item.data_byte == SECTION_MESSAGES);
                        acc_next     = '0;
                        hdr_pos_next = 3'd1;
                    end
                    else if (hdr_pos_reg == 3'(HDR_LAST))
                    begin
                        hdr_pos_next      = '0;
                        section_left_next = acc_shift;
                        acc_next          = '0;
                        tag_phase_next    = TG_EXPECT;
                        skip_left_next    = '0;
                        count_next        = '0;
                        if (acc_shift == '0)
                        begin
                            // empty section closes on its last header byte
                            closed = in_msg_reg;
                        end
                        else
                        begin
                            phase_next = PH_BODY;
                        end
                    end
                    else
                    begin
                        acc_next     = acc_shift;
                        hdr_pos_next = hdr_pos_reg + 3'd1;
                    end
                end
                PH_BODY:
                begin
                    if (in_msg_reg)
                    begin
                        unique case (tag_phase_reg)
                            TG_EXPECT:
                            begin
                                case (item.data_byte) inside
                                    TAG_PADDING:
                                    begin
                                    end
                                    TAG_FIXED4:
                                    begin
                                        skip_left_next = 32'd4;
                                        tag_phase_next = TG_SKIP;
                                    end
                                    TAG_TRANSLATION, TAG_DATA6, TAG_DATA7, TAG_DATA8:
                                    begin
                                        if (item.data_byte == TAG_TRANSLATION &&
                                            count_reg != '1)
                                        begin
                                            count_next = count_reg + 32'd1;
                                        end
                                        acc_next       = '0;
                                        len_pos_next   = '0;
                                        tag_phase_next = TG_LEN;
                                    end
                                    default:
                                    begin
                                        tag_phase_next = TG_STOPPED;
                                    end
                                endcase
                            end
                            TG_LEN:
                            begin
                                acc_next = acc_shift;
                                if (len_pos_reg == 2'd3)
                                begin
                                    if (acc_shift == NO_BODY || acc_shift == '0)
                                    begin
                                        tag_phase_next = TG_EXPECT;
                                    end
                                    else
                                    begin
                                        skip_left_next = acc_shift;
                                        tag_phase_next = TG_SKIP;
                                    end
                                end
                                else
                                begin
                                    len_pos_next = len_pos_reg + 2'd1;
                                end
                            end
                            TG_SKIP:
                            begin
                                skip_left_next = skip_left_reg - 32'd1;
                                if (skip_left_reg == 32'd1)
                                begin
                                    tag_phase_next = TG_EXPECT;
                                end
                            end
                            TG_STOPPED:
                            begin
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                    // body is entered with a nonzero length
                    section_left_next = section_left_reg - 32'd1;
                    if (section_left_reg == 32'd1)
                    begin
                        closed       = in_msg_reg;
                        closed_count = count_next;
                        phase_next   = PH_HEADER;
                        hdr_pos_next = '0;
                    end
                end
                PH_FAILED:
                begin
                end
                default:
                begin
                end
            endcase

            if (item.last_byte)
            begin
                if (phase_next == PH_MAGIC || phase_next == PH_FAILED)
                begin
                    file_status = STATUS_BAD_MAGIC;
                end
                else if (phase_next == PH_BODY || hdr_pos_next != '0)
                begin
                    file_status = STATUS_TRUNCATED;
                end
                else
                begin
                    file_status = STATUS_OK;
                end
                // back to the start for the next file
                phase_next        = PH_MAGIC;
                magic_pos_next    = '0;
                hdr_pos_next      = '0;
                in_msg_next       = 1'b0;
                section_left_next = '0;
                acc_next          = '0;
                tag_phase_next    = TG_EXPECT;
                len_pos_next      = '0;
                skip_left_next    = '0;
                count_next        = '0;
            end
        end
    end

    assign push             = item.valid && (closed || item.last_byte);
    assign entry.has_count  = closed;
    assign entry.count      = closed_count;
    assign entry.has_status = item.last_byte;
    assign entry.status     = file_status;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_MAGIC;
            magic_pos_reg    <= '0;
            hdr_pos_reg      <= '0;
            in_msg_reg       <= 1'b0;
            section_left_reg <= '0;
            acc_reg          <= '0;
            tag_phase_reg    <= TG_EXPECT;
            len_pos_reg      <= '0;
            skip_left_reg    <= '0;
            count_reg        <= '0;
        end
        else
        begin
            phase_reg        <= phase_next;
            magic_pos_reg    <= magic_pos_next;
            hdr_pos_reg      <= hdr_pos_next;
            in_msg_reg       <= in_msg_next;
            section_left_reg <= section_left_next;
            acc_reg          <= acc_next;
            tag_phase_reg    <= tag_phase_next;
            len_pos_reg      <= len_pos_next;
            skip_left_reg    <= skip_left_next;
            count_reg        <= count_next;
        end
    end

`ifndef SYNTHESIS
    a_last_gives_status: assert property (@(posedge clk) disable iff (!rst_n)
        item.valid && item.last_byte |-> push && entry.has_status)
        else $error("final byte did not produce a status");

    a_no_item_no_push: assert property (@(posedge clk) disable iff (!rst_n)
        !item.valid |-> !push)
        else $error("result produced without an item");

    a_restart_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        item.valid && item.last_byte |=> phase_reg == PH_MAGIC && magic_pos_reg == '0)
        else $error("parser did not restart after the final byte");

    a_body_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_BODY |-> section_left_reg != '0)
        else $error("section body with nothing left");
`endif

endmodule

/* design/qcsc_out_queue.sv */
`timescale 1ns / 1ps
// qcsc_out_queue: small queue of result entries, one or two results each
// depends on qcsc_pkg and result_if

module qcsc_out_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  qcsc_pkg::entry_t entry,
    output logic [$clog2(qcsc_pkg::FIFO_DEPTH + 1) - 1:0] count,
    result_if.source         results
);
    import qcsc_pkg::*;

    localparam int PTR_W = $clog2(FIFO_DEPTH);
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

    entry_t             slots [FIFO_DEPTH];
    logic [PTR_W - 1:0] wr_ptr_reg;
    logic [PTR_W - 1:0] rd_ptr_reg;
    logic [CNT_W - 1:0] count_reg, count_next;
    logic               sub_reg;

    entry_t head;
    logic   show_count;
    logic   xfer;
    logic   pop;

    assign head       = slots[rd_ptr_reg];
    assign show_count = !sub_reg && head.has_count;
    assign xfer       = results.valid && results.ready;
    // entry leaves once its status, or its lone count, is transferred
    assign pop        = xfer && (!show_count || !head.has_status);

    assign results.valid        = count_reg != '0;
    assign results.result_kind  = show_count ? KIND_COUNT : KIND_STATUS;
    assign results.string_count = show_count ? head.count : '0;
    assign results.status       = show_count ? STATUS_OK : head.status;
    assign results.last_result  = show_count ? !head.has_status : 1'b1;

    assign count = count_reg;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (!push && pop)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots[wr_ptr_reg] <= entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
            sub_reg    <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
                sub_reg    <= 1'b0;
            end
            else if (xfer && show_count)
            begin
                sub_reg <= 1'b1;
            end
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> count_reg != CNT_W'(FIFO_DEPTH) || pop)
        else $error("result queue overflow");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(FIFO_DEPTH))
        else $error("result queue count out of range");

    a_sub_has_entry: assert property (@(posedge clk) disable iff (!rst_n)
        sub_reg |-> count_reg != '0 && head.has_status)
        else $error("second result pending without an entry");
`endif

endmodule

/* sim/tb.sv */
`timescale 1ns / 1ps
// tb: testbench of qm_catalog_string_counter, catalog files in, counts and status out
// depends on qcsc_pkg, byte_if, result_if and the qm_catalog_string_counter top level

module tb;
    import qcsc_pkg::*;

    localparam int STALL_LIMIT  = 1000;
    localparam int DRAIN_CYCLES = 20;
    localparam int HOLD_CYCLES  = 150;
    localparam int RANDOM_BYTES = 150;

    localparam logic [7:0] UNKNOWN_TAG   = 8'h02;
    localparam logic [7:0] OTHER_SECTION = 8'h00;
    localparam logic [7:0] SPARE_SECTION = 8'hff;

    typedef struct {
        logic        kind;
        logic [31:0] count;
        logic [1:0]  status;
        logic        last;
    } catalog_report_t;

    logic clk;
    logic rst_n;

    byte_if   byte_ch ();
    result_if res_ch ();

    qm_catalog_string_counter dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .bytes   (byte_ch),
        .results (res_ch)
    );

    // parser state of the prediction
    phase_t      cat_phase;
    logic [4:0]  cat_magic_pos;
    logic [2:0]  cat_hdr_pos;
    logic        cat_in_msg;
    logic [31:0] cat_section_left;
    logic [31:0] cat_len_acc;
    tag_phase_t  cat_tag;
    logic [1:0]  cat_tag_len_idx;
    logic [31:0] cat_skip_left;
    logic [31:0] cat_count;
    logic [1:0]  cat_err;

    catalog_report_t pending_reports[$];
    logic [7:0]      file_bytes[$];
    logic [7:0]      body_bytes[$];

    int error_count;
    int random_bytes_sent;
    bit idle_on;
    int hold_left;
    int stall_left;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic void clear_catalog_state();
        cat_phase        = PH_MAGIC;
        cat_magic_pos    = '0;
        cat_hdr_pos      = '0;
        cat_in_msg       = 1'b0;
        cat_section_left = '0;
        cat_len_acc      = '0;
        cat_tag          = TG_EXPECT;
        cat_tag_len_idx  = '0;
        cat_skip_left    = '0;
        cat_count        = '0;
        cat_err          = STATUS_OK;
    endfunction

    function automatic void walk_tag(input logic [7:0] b);
        case (cat_tag)
            TG_EXPECT:
            begin
                if (b == TAG_PADDING)
                begin
                end
                else if (b == TAG_FIXED4)
                begin
                    cat_skip_left = 32'd4;
                    cat_tag       = TG_SKIP;
                end
                else if (b inside {TAG_TRANSLATION, TAG_DATA6, TAG_DATA7, TAG_DATA8})
                begin
                    if (b == TAG_TRANSLATION && cat_count != 32'hffff_ffff)
                        cat_count = cat_count + 32'd1;
                    cat_len_acc     = '0;
                    cat_tag_len_idx = '0;
                    cat_tag         = TG_LEN;
                end
                else
                    cat_tag = TG_STOPPED;
            end
            TG_LEN:
            begin
                cat_len_acc = {cat_len_acc[23:0], b};
                if (cat_tag_len_idx == 2'd3)
                begin
                    if (cat_len_acc == NO_BODY || cat_len_acc == 32'd0)
                        cat_tag = TG_EXPECT;
                    else
                    begin
                        cat_skip_left = cat_len_acc;
                        cat_tag       = TG_SKIP;
                    end
                end
                else
                    cat_tag_len_idx = cat_tag_len_idx + 2'd1;
            end
            TG_SKIP:
            begin
                if (cat_skip_left > 0)
                    cat_skip_left = cat_skip_left - 32'd1;
                if (cat_skip_left == 0)
                    cat_tag = TG_EXPECT;
            end
            default:
            begin
            end
        endcase
    endfunction

    // works out the reports one accepted byte causes and queues them
    function automatic void tally_byte(input logic [7:0] b, input logic is_last);
        logic            closed;
        logic [31:0]     closed_count;
        catalog_report_t rep;
        closed       = 1'b0;
        closed_count = '0;
        case (cat_phase)
            PH_MAGIC:
            begin
                if (b == CATALOG_MAGIC[cat_magic_pos[3:0]])
                begin
                    cat_magic_pos = cat_magic_pos + 5'd1;
                    if (cat_magic_pos == MAGIC_LEN)
                    begin
                        cat_phase   = PH_HEADER;
                        cat_hdr_pos = '0;
                    end
                end
                else
                begin
                    cat_phase = PH_FAILED;
                    cat_err   = STATUS_BAD_MAGIC;
                end
            end
            PH_HEADER:
            begin
                if (cat_hdr_pos == 0)
                begin
                    cat_in_msg  = (b == SECTION_MESSAGES);
                    cat_len_acc = '0;
                    cat_hdr_pos = 3'd1;
                end
                else
                begin
                    cat_len_acc = {cat_len_acc[23:0], b};
                    if (cat_hdr_pos >= HDR_LAST)
                    begin
                        cat_hdr_pos      = '0;
                        cat_section_left = cat_len_acc;
                        cat_len_acc      = '0;
                        cat_tag          = TG_EXPECT;
                        cat_skip_left    = '0;
                        cat_count        = '0;
                        // empty section closes on its last header byte
                        if (cat_section_left == 0)
                            closed = cat_in_msg;
                        else
                            cat_phase = PH_BODY;
                    end
                    else
                        cat_hdr_pos = cat_hdr_pos + 3'd1;
                end
            end
            PH_BODY:
            begin
                if (cat_in_msg)
                    walk_tag(b);
                if (cat_section_left > 0)
                    cat_section_left = cat_section_left - 32'd1;
                if (cat_section_left == 0)
                begin
                    closed       = cat_in_msg;
                    closed_count = cat_count;
                    cat_phase    = PH_HEADER;
                    cat_hdr_pos  = '0;
                end
            end
            default:
            begin
            end
        endcase

        if (closed)
        begin
            rep.kind   = KIND_COUNT;
            rep.count  = closed_count;
            rep.status = STATUS_OK;
            rep.last   = !is_last;
            pending_reports.push_back(rep);
        end

        if (is_last)
        begin
            rep.kind  = KIND_STATUS;
            rep.count = '0;
            rep.last  = 1'b1;
            if (cat_err != STATUS_OK)
                rep.status = cat_err;
            else if (cat_phase == PH_MAGIC || cat_phase == PH_FAILED)
                rep.status = STATUS_BAD_MAGIC;
            else if (cat_phase == PH_BODY || cat_hdr_pos != 0)
                rep.status = STATUS_TRUNCATED;
            else
                rep.status = STATUS_OK;
            pending_reports.push_back(rep);
            clear_catalog_state();
        end
    endfunction

    // starts at any time, returns at the rising edge of the transfer
    task automatic send_byte(input logic [7:0] value, input logic is_last);
        int gap;
        gap = idle_on ? $urandom_range(0, 12) : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            byte_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        byte_ch.valid     <= 1'b1;
        byte_ch.data_byte <= value;
        byte_ch.last_byte <= is_last;
        do
            @(posedge clk);
        while (!byte_ch.ready);
        tally_byte(value, is_last);
    endtask

    task automatic send_file();
        int i;
        for (i = 0; i < file_bytes.size(); i++)
            send_byte(file_bytes[i], i == file_bytes.size() - 1);
        file_bytes.delete();
    endtask

    task automatic put_word(ref logic [7:0] q[$], input logic [31:0] w);
        q.push_back(w[31:24]);
        q.push_back(w[23:16]);
        q.push_back(w[15:8]);
        q.push_back(w[7:0]);
    endtask

    task automatic put_magic(input int n);
        int i;
        for (i = 0; i < n; i++)
            file_bytes.push_back(CATALOG_MAGIC[i]);
    endtask

    // header with the given length, then whatever body was built
    task automatic close_section(input logic [7:0] kind, input logic [31:0] len);
        file_bytes.push_back(kind);
        put_word(file_bytes, len);
        foreach (body_bytes[i])
            file_bytes.push_back(body_bytes[i]);
        body_bytes.delete();
    endtask

    task automatic put_tag_with_len(input logic [7:0] tag, input logic [31:0] len, input int n);
        int i;
        body_bytes.push_back(tag);
        put_word(body_bytes, len);
        for (i = 0; i < n; i++)
            body_bytes.push_back(8'($urandom_range(0, 255)));
    endtask

    task automatic put_random_tag();
        int          pick;
        int          n;
        logic [7:0]  tag;
        logic [31:0] len;
        pick = $urandom_range(0, 11);
        case (pick)
            0, 1: tag = TAG_PADDING;
            2, 3, 4: tag = TAG_TRANSLATION;
            5: tag = TAG_FIXED4;
            6: tag = TAG_DATA6;
            7: tag = TAG_DATA7;
            8: tag = TAG_DATA8;
            default: tag = 8'($urandom_range(0, 255));
        endcase
        if (tag inside {TAG_TRANSLATION, TAG_DATA6, TAG_DATA7, TAG_DATA8})
        begin
            n = 0;
            case ($urandom_range(0, 7))
                0: len = NO_BODY;
                1: len = 32'd0;
                2: len = $urandom;
                default:
                begin
                    n   = $urandom_range(1, 5);
                    len = 32'(n);
                end
            endcase
            put_tag_with_len(tag, len, n);
        end
        else
        begin
            body_bytes.push_back(tag);
            if (tag == TAG_FIXED4)
                repeat (4) body_bytes.push_back(8'($urandom_range(0, 255)));
        end
    endtask

    task automatic build_random_file();
        int          shape;
        int          n;
        int          p;
        int          keep;
        int          s;
        logic [7:0]  kind;
        logic [31:0] len;
        shape = $urandom_range(0, 9);
        if (shape == 0)
        begin
            n = $urandom_range(1, 24);
            repeat (n) file_bytes.push_back(8'($urandom_range(0, 255)));
        end
        else if (shape == 1)
        begin
            put_magic($urandom_range(1, MAGIC_LEN));
            if ($urandom_range(0, 1) == 1)
            begin
                p = $urandom_range(0, file_bytes.size() - 1);
                file_bytes[p] = file_bytes[p] ^ 8'($urandom_range(1, 255));
                repeat ($urandom_range(0, 5)) file_bytes.push_back(8'($urandom_range(0, 255)));
            end
        end
        else
        begin
            put_magic(MAGIC_LEN);
            for (s = $urandom_range(1, 4); s > 0; s--)
            begin
                kind = ($urandom_range(0, 3) != 0) ? SECTION_MESSAGES
                                                  : 8'($urandom_range(0, 255));
                if (kind == SECTION_MESSAGES)
                    repeat ($urandom_range(0, 6)) put_random_tag();
                else
                    repeat ($urandom_range(0, 8)) body_bytes.push_back(8'($urandom_range(0, 255)));
                len = 32'(body_bytes.size());
                // declared length off from the body now and then
                case ($urandom_range(0, 9))
                    0: len = len + 32'($urandom_range(1, 4));
                    1: if (len > 0) len = len - 32'($urandom_range(1, int'(len)));
                    default:
                    begin
                    end
                endcase
                close_section(kind, len);
            end
            if ($urandom_range(0, 5) == 0)
            begin
                keep = $urandom_range(1, file_bytes.size());
                while (file_bytes.size() > keep)
                    void'(file_bytes.pop_back());
            end
        end
    endtask

    task automatic test_magic_check();
        // short file of one byte
        put_magic(1);
        send_file();
        // short file cut inside the magic
        put_magic(7);
        send_file();
        // bad magic, later bytes ignored
        put_magic(1);
        file_bytes.push_back(8'h00);
        file_bytes.push_back(CATALOG_MAGIC[2]);
        file_bytes.push_back(8'hff);
        file_bytes.push_back(SECTION_MESSAGES);
        send_file();
        // mismatch on the final byte itself
        file_bytes.push_back(8'hff);
        send_file();
    endtask

    task automatic test_section_close();
        put_magic(MAGIC_LEN);
        close_section(SECTION_MESSAGES, 32'd0);
        close_section(OTHER_SECTION, 32'd0);
        // tag length runs past the section end; closes on the final byte
        body_bytes.push_back(TAG_TRANSLATION);
        body_bytes.push_back(8'h00);
        body_bytes.push_back(8'h00);
        close_section(SECTION_MESSAGES, 32'd3);
        send_file();
    endtask

    task automatic test_tag_walk();
        put_magic(MAGIC_LEN);
        body_bytes.push_back(TAG_PADDING);
        put_tag_with_len(TAG_TRANSLATION, NO_BODY, 0);
        put_tag_with_len(TAG_TRANSLATION, 32'd0, 0);
        body_bytes.push_back(TAG_FIXED4);
        repeat (4) body_bytes.push_back(TAG_TRANSLATION);
        put_tag_with_len(TAG_DATA6, 32'd2, 2);
        put_tag_with_len(TAG_DATA7, NO_BODY, 0);
        put_tag_with_len(TAG_DATA8, 32'd1, 0);
        body_bytes.push_back(TAG_TRANSLATION);
        put_tag_with_len(TAG_TRANSLATION, 32'd1, 0);
        body_bytes.push_back(TAG_TRANSLATION);
        // walk stops here for the rest of the section
        body_bytes.push_back(UNKNOWN_TAG);
        repeat (3) body_bytes.push_back(TAG_TRANSLATION);
        close_section(SECTION_MESSAGES, 32'(body_bytes.size()));
        // translation tags outside a messages section are not counted
        repeat (4) body_bytes.push_back(TAG_TRANSLATION);
        close_section(OTHER_SECTION, 32'(body_bytes.size()));
        // tag body longer than the section, dropped at the boundary
        put_tag_with_len(TAG_TRANSLATION, 32'h7fff_ffff, 2);
        close_section(SECTION_MESSAGES, 32'(body_bytes.size()));
        put_tag_with_len(TAG_TRANSLATION, NO_BODY, 0);
        close_section(SECTION_MESSAGES, 32'(body_bytes.size()));
        close_section(SPARE_SECTION, 32'd0);
        send_file();
    endtask

    task automatic test_truncation();
        // cut after the type byte
        put_magic(MAGIC_LEN);
        file_bytes.push_back(SECTION_MESSAGES);
        send_file();
        // cut inside the length
        put_magic(MAGIC_LEN);
        file_bytes.push_back(SECTION_MESSAGES);
        file_bytes.push_back(8'h00);
        file_bytes.push_back(8'h00);
        send_file();
        // body shorter than declared
        put_magic(MAGIC_LEN);
        repeat (3) body_bytes.push_back(TAG_TRANSLATION);
        close_section(SECTION_MESSAGES, 32'd10);
        send_file();
        // largest section length
        put_magic(MAGIC_LEN);
        body_bytes.push_back(TAG_PADDING);
        body_bytes.push_back(TAG_TRANSLATION);
        close_section(OTHER_SECTION, 32'hffff_ffff);
        send_file();
    endtask

    task automatic test_backpressure();
        idle_on = 1'b0;
        // receiver holds off while a stream of empty messages sections goes in
        hold_left = HOLD_CYCLES;
        put_magic(MAGIC_LEN);
        repeat (10) close_section(SECTION_MESSAGES, 32'd0);
        send_file();
        idle_on = 1'b1;
    endtask

    task automatic test_random_files();
        while (random_bytes_sent < RANDOM_BYTES)
        begin
            idle_on = ($urandom_range(0, 3) != 0);
            build_random_file();
            random_bytes_sent += file_bytes.size();
            send_file();
        end
        idle_on = 1'b1;
    endtask

    // result receiver: long hold-off first, then per-transfer stalls
    initial
    begin
        res_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                res_ch.ready <= 1'b0;
                hold_left--;
            end
            else if (stall_left > 0)
            begin
                res_ch.ready <= 1'b0;
                stall_left--;
            end
            else
                res_ch.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        catalog_report_t want;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            stall_left = idle_on ? $urandom_range(0, 12) : 0;
            if (pending_reports.size() == 0)
            begin
                $error("unexpected result: kind %0d count %0d status %0d last %0d",
                       res_ch.result_kind, res_ch.string_count, res_ch.status,
                       res_ch.last_result);
                error_count++;
            end
            else
            begin
                want = pending_reports.pop_front();
                if (res_ch.result_kind !== want.kind)
                begin
                    $error("result_kind: expected %0d, got %0d", want.kind, res_ch.result_kind);
                    error_count++;
                end
                if (res_ch.string_count !== want.count)
                begin
                    $error("string_count: expected %0d, got %0d", want.count,
                           res_ch.string_count);
                    error_count++;
                end
                if (res_ch.status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, res_ch.status);
                    error_count++;
                end
                if (res_ch.last_result !== want.last)
                begin
                    $error("last_result: expected %0d, got %0d", want.last,
                           res_ch.last_result);
                    error_count++;
                end
            end
        end
    end

    // ends the run when neither channel has a transfer for too long
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((byte_ch.valid && byte_ch.ready) || (res_ch.valid && res_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("tb: done, errors");
        $finish;
    end

    initial
    begin
        rst_n             = 1'b0;
        byte_ch.valid     = 1'b0;
        byte_ch.data_byte = '0;
        byte_ch.last_byte = 1'b0;
        error_count       = 0;
        random_bytes_sent = 0;
        idle_on           = 1'b1;
        hold_left         = 0;
        stall_left        = 0;
        clear_catalog_state();
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_magic_check();
        test_section_close();
        test_tag_walk();
        test_truncation();
        test_backpressure();
        test_random_files();

        @(negedge clk);
        byte_ch.valid <= 1'b0;
        while (pending_reports.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule
